// ===== src/microwire_eeprom_master_unit_assert.svh =====
// Assertion shorthands used by the block's sequencer module.
`ifndef MICROWIRE_EEPROM_MASTER_UNIT_ASSERT_SVH
`define MICROWIRE_EEPROM_MASTER_UNIT_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define MWEM_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define MWEM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mwem_pkg.sv =====
package mwem_pkg;

  localparam int FRAME_W = 30;
  localparam int ADDR_W  = 11;
  localparam int DATA_W  = 16;
  localparam int CNT_W   = 5;
  localparam int AW_W    = 4;

  // Command codes on the request side
  localparam logic [2:0] FN_READ  = 3'd0;
  localparam logic [2:0] FN_WRITE = 3'd1;
  localparam logic [2:0] FN_ERASE = 3'd2;
  localparam logic [2:0] FN_EWEN  = 3'd3;
  localparam logic [2:0] FN_EWDS  = 3'd4;
  localparam logic [2:0] FN_ERAL  = 3'd5;
  localparam logic [2:0] FN_WRAL  = 3'd6;
  localparam logic [2:0] FN_NONE  = 3'd7;

  // Opcodes on the wire
  localparam logic [1:0] OP_CTRL  = 2'b00;
  localparam logic [1:0] OP_WRITE = 2'b01;
  localparam logic [1:0] OP_READ  = 2'b10;
  localparam logic [1:0] OP_ERASE = 2'b11;

  // Control codes carried in the top two address bits
  localparam logic [1:0] CC_EWEN = 2'b11;
  localparam logic [1:0] CC_EWDS = 2'b00;
  localparam logic [1:0] CC_ERAL = 2'b10;
  localparam logic [1:0] CC_WRAL = 2'b01;

  // Configuration register indexes
  localparam logic CFG_ORG_WORD   = 1'b0;
  localparam logic CFG_MODEL_CODE = 1'b1;

  // Device model codes
  localparam logic [2:0] MDL_56 = 3'd1;
  localparam logic [2:0] MDL_66 = 3'd2;
  localparam logic [2:0] MDL_76 = 3'd3;
  localparam logic [2:0] MDL_86 = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_SEND = 3'd1,
    PH_READ = 3'd2,
    PH_GAP  = 3'd3,
    PH_WAIT = 3'd4,
    PH_END  = 3'd5
  } phase_t;

  typedef struct packed {
    logic       org_word;
    logic [2:0] model_code;
  } cfg_t;

  typedef struct packed {
    logic              start_req;
    logic [2:0]        func;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    logic              data_out_pin;
  } tick_t;

  typedef struct packed {
    logic              chip_select;
    logic              serial_clock;
    logic              data_in_pin;
    logic              busy_res;
    logic              done_res;
    logic              rejected;
    logic [DATA_W-1:0] read_data;
  } res_t;

endpackage

// ===== src/mwem_frame.sv =====
module mwem_frame #(
  parameter int MAX_ADDRESS_BITS = 11
) (
  input  mwem_pkg::cfg_t                  cfg,
  input  logic [2:0]                      func,
  input  logic [mwem_pkg::ADDR_W-1:0]     address,
  input  logic [mwem_pkg::DATA_W-1:0]     write_data,
  output logic [mwem_pkg::FRAME_W-1:0]    frame,
  output logic [mwem_pkg::CNT_W-1:0]      frame_len
);
  import mwem_pkg::*;

  logic [AW_W-1:0]   aw_raw;
  logic [AW_W-1:0]   aw;
  logic [ADDR_W-1:0] amask;
  logic [1:0]        op;
  logic [1:0]        ccode;
  logic              is_ctrl;
  logic [13:0]       low;
  logic [13:0]       word;
  logic              has_data;

  // Address width: 7 bytes / 6 words, plus 2 or 4 for the larger parts
  always_comb begin
    aw_raw = cfg.org_word ? AW_W'(6) : AW_W'(7);
    if (cfg.model_code == MDL_56 || cfg.model_code == MDL_66) begin
      aw_raw = aw_raw + AW_W'(2);
    end else if (cfg.model_code == MDL_76 || cfg.model_code == MDL_86) begin
      aw_raw = aw_raw + AW_W'(4);
    end
    aw = (aw_raw > AW_W'(MAX_ADDRESS_BITS)) ? AW_W'(MAX_ADDRESS_BITS) : aw_raw;
  end

  always_comb begin
    op      = OP_CTRL;
    ccode   = CC_WRAL;
    is_ctrl = 1'b0;
    case (func)
      FN_READ:  op = OP_READ;
      FN_WRITE: op = OP_WRITE;
      FN_ERASE: op = OP_ERASE;
      FN_EWEN: begin
        is_ctrl = 1'b1;
        ccode   = CC_EWEN;
      end
      FN_EWDS: begin
        is_ctrl = 1'b1;
        ccode   = CC_EWDS;
      end
      FN_ERAL: begin
        is_ctrl = 1'b1;
        ccode   = CC_ERAL;
      end
      default: begin
        is_ctrl = 1'b1;
        ccode   = CC_WRAL;
      end
    endcase
  end

  assign amask    = ~({ADDR_W{1'b1}} << aw);
  assign low      = is_ctrl ? (14'(ccode) << (aw - AW_W'(2)))
                            : 14'(address & amask);
  assign word     = (14'({1'b1, op}) << aw) | low;
  assign has_data = (func == FN_WRITE) || (func == FN_WRAL);

  always_comb begin
    frame     = FRAME_W'(word);
    frame_len = CNT_W'(aw) + CNT_W'(3);
    if (has_data) begin
      if (cfg.org_word) begin
        frame     = (FRAME_W'(word) << 16) | FRAME_W'(write_data);
        frame_len = frame_len + CNT_W'(16);
      end else begin
        frame     = (FRAME_W'(word) << 8) | FRAME_W'(write_data[7:0]);
        frame_len = frame_len + CNT_W'(8);
      end
    end
  end

endmodule

// ===== src/mwem_seq.sv =====
module mwem_seq #(
  parameter int MAX_ADDRESS_BITS = 11
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  mwem_pkg::cfg_t  cfg,
  input  mwem_pkg::tick_t tick,
  output mwem_pkg::res_t  res
);
  import mwem_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [CNT_W-1:0]    bit_r, bit_nxt;
  logic                half_r, half_nxt;
  logic [FRAME_W-1:0]  frame_r, frame_nxt;
  logic [DATA_W-1:0]   accum_r, accum_nxt;
  logic                ew_en_r, ew_en_nxt;
  logic [2:0]          pend_r, pend_nxt;

  logic [FRAME_W-1:0]  new_frame;
  logic [CNT_W-1:0]    new_len;
  logic                req_ok;
  logic                wtype;
  logic                go;
  logic [CNT_W-1:0]    bit_idx;
  logic [31:0]         frame_ext;

  mwem_frame #(
    .MAX_ADDRESS_BITS(MAX_ADDRESS_BITS)
  ) u_frame (
    .cfg        (cfg),
    .func       (tick.func),
    .address    (tick.address),
    .write_data (tick.write_data),
    .frame      (new_frame),
    .frame_len  (new_len)
  );

  assign req_ok    = tick.start_req && (tick.func != FN_NONE);
  assign wtype     = (tick.func == FN_WRITE) || (tick.func == FN_ERASE) ||
                     (tick.func == FN_ERAL) || (tick.func == FN_WRAL);
  assign go        = req_ok && !(wtype && !ew_en_r);
  assign bit_idx   = bit_r - CNT_W'(1);
  assign frame_ext = {{(32-FRAME_W){1'b0}}, frame_r};

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    half_nxt  = half_r;
    frame_nxt = frame_r;
    accum_nxt = accum_r;
    ew_en_nxt = ew_en_r;
    pend_nxt  = pend_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (go) begin
          frame_nxt = new_frame;
          bit_nxt   = new_len;
          half_nxt  = 1'b0;
          pend_nxt  = tick.func;
          phase_nxt = PH_SEND;
          if (tick.func == FN_READ) accum_nxt = '0;
        end
      end
      PH_SEND: begin
        if (bit_r != '0 && !half_r) begin
          half_nxt = 1'b1;
        end else if (bit_r == '0 || bit_r == CNT_W'(1)) begin
          // frame finished: pick the follow-on phase
          half_nxt = 1'b0;
          bit_nxt  = '0;
          if (pend_r == FN_READ) begin
            bit_nxt   = cfg.org_word ? CNT_W'(16) : CNT_W'(8);
            phase_nxt = PH_READ;
          end else if (pend_r == FN_EWEN || pend_r == FN_EWDS) begin
            phase_nxt = PH_END;
          end else begin
            phase_nxt = PH_GAP;
          end
        end else begin
          half_nxt = 1'b0;
          bit_nxt  = bit_r - CNT_W'(1);
        end
      end
      PH_READ: begin
        if (bit_r == '0) begin
          phase_nxt = PH_END;
        end else if (!half_r) begin
          accum_nxt = {accum_r[DATA_W-2:0], tick.data_out_pin};
          half_nxt  = 1'b1;
        end else begin
          half_nxt = 1'b0;
          bit_nxt  = bit_r - CNT_W'(1);
          if (bit_r == CNT_W'(1)) phase_nxt = PH_END;
        end
      end
      PH_GAP:  phase_nxt = PH_WAIT;
      PH_WAIT: if (tick.data_out_pin) phase_nxt = PH_END;
      PH_END: begin
        if (pend_r == FN_EWEN) ew_en_nxt = 1'b1;
        if (pend_r == FN_EWDS) ew_en_nxt = 1'b0;
        phase_nxt = PH_IDLE;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // Line levels and status for this tick
  always_comb begin
    res           = '0;
    res.read_data = accum_nxt;
    unique case (phase_r)
      PH_IDLE: begin
        res.rejected    = req_ok && !go;
        res.chip_select = go;
        res.busy_res    = go;
      end
      PH_SEND: begin
        res.chip_select = 1'b1;
        res.busy_res    = 1'b1;
        if (bit_r != '0) begin
          res.data_in_pin  = frame_ext[bit_idx];
          res.serial_clock = half_r;
        end
      end
      PH_READ: begin
        res.chip_select  = 1'b1;
        res.busy_res     = 1'b1;
        res.serial_clock = (bit_r != '0) && !half_r;
      end
      PH_GAP:  res.busy_res = 1'b1;
      PH_WAIT: begin
        res.chip_select = 1'b1;
        res.busy_res    = 1'b1;
      end
      PH_END:  res.done_res = 1'b1;
      default: res.done_res = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bit_r   <= '0;
      half_r  <= 1'b0;
      accum_r <= '0;
      ew_en_r <= 1'b0;
      pend_r  <= FN_READ;
    end else if (advance) begin
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      half_r  <= half_nxt;
      accum_r <= accum_nxt;
      ew_en_r <= ew_en_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) frame_r <= frame_nxt;
  end

`include "microwire_eeprom_master_unit_assert.svh"

  `MWEM_ASSERT_NEXT(a_ew_only_at_end, clk, rst_n, !(advance && phase_r == PH_END), $stable(ew_en_r), "write enable changed outside command end")
  `MWEM_ASSERT_NOW(a_send_has_bits, clk, rst_n, phase_r == PH_SEND, bit_r != '0, "frame phase with no bits left")
  `MWEM_ASSERT_NOW(a_reject_not_busy, clk, rst_n, res.rejected, !res.busy_res && !res.chip_select, "rejected request drove the bus")
  `MWEM_ASSERT_NOW(a_done_from_end, clk, rst_n, res.done_res, phase_r == PH_END && !res.busy_res, "done outside command end")

endmodule

// ===== src/microwire_eeprom_master_unit.sv =====
// Channel   | Handshake              | Payload
// ----------+------------------------+------------------------------------------------
// in_       | in_tvalid / in_tready  | one serial clock half-period tick request
// out_      | out_tvalid / out_tready| line levels and status for that tick
// cfg_      | cfg_we                 | cfg_addr selects org_word (0) or model_code (1)
//
// Each request yields exactly one result; sustained rate is one request per clock while out_tready stays high.
// A request passes through the request register, then the sequencer step into the result register.
// A full result register that is not taken holds the sequencer; the request register
// still fills, so in_tready drops only when both stages are full.
// Reset (rst_n low, synchronous) empties both stages, sets org_word=1, model_code=0,
// puts the sequencer idle and disables writes.
module microwire_eeprom_master_unit #(
  parameter int MAX_ADDRESS_BITS = 11
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] start_req, [3:1] func, [14:4] address, [30:15] write_data, [31] data_out_pin
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] chip_select, [1] serial_clock, [2] data_in_pin, [3] busy_res, [4] done_res,
  // [5] rejected, [21:6] read_data, [23:22] zero
  output logic [23:0] out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [2:0]  cfg_wdata
);
  import mwem_pkg::*;

  cfg_t   cfg_r;
  logic   in_v_r;
  tick_t  in_item_r;
  logic   out_v_r;
  res_t   out_res_r;
  res_t   step_res;
  logic   out_load;
  logic   advance;

  // Result register can take a new value when empty or being drained
  assign out_load  = !out_v_r || out_tready;
  assign advance   = in_v_r && out_load;
  assign in_tready = !in_v_r || out_load;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.org_word   <= 1'b1;
      cfg_r.model_code <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ORG_WORD:   cfg_r.org_word   <= cfg_wdata[0];
        CFG_MODEL_CODE: cfg_r.model_code <= cfg_wdata;
        default:        cfg_r            <= cfg_r;
      endcase
    end
  end

  // Request register: load on accept, drop when the sequencer consumes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.start_req    <= in_tdata[0];
      in_item_r.func         <= in_tdata[3:1];
      in_item_r.address      <= in_tdata[14:4];
      in_item_r.write_data   <= in_tdata[30:15];
      in_item_r.data_out_pin <= in_tdata[31];
    end
  end

  mwem_seq #(
    .MAX_ADDRESS_BITS(MAX_ADDRESS_BITS)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .cfg     (cfg_r),
    .tick    (in_item_r),
    .res     (step_res)
  );

  // Result register: advance with the sequencer, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res_r <= step_res;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_res_r.read_data, out_res_r.rejected,
                       out_res_r.done_res, out_res_r.busy_res, out_res_r.data_in_pin,
                       out_res_r.serial_clock, out_res_r.chip_select};

endmodule
